@@ design/lrupr_pkg.sv @@
// shared constants and scan/update word types for the lru page replacement block
`default_nettype none
package lrupr_pkg;

    // defaults and fixed field widths
    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;
    localparam int PAGE_IN_W     = 16;
    localparam int SLOT_W        = 3;
    localparam int CFG_W         = 4;
    localparam int CNT_W         = 32;

    // widths that cover the largest supported frame count and page size
    localparam int IDX_W_MAX  = 6;
    localparam int RANK_W_MAX = 6;
    localparam int PAGE_W_MAX = 32;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 4'd8;

    // search word handed from cell to cell
    typedef struct packed {
        logic                  vld;
        logic                  match_found;
        logic [IDX_W_MAX-1:0]  match_idx;
        logic [RANK_W_MAX-1:0] match_rank;
        logic                  empty_found;
        logic [IDX_W_MAX-1:0]  empty_idx;
        logic                  best_found;
        logic [RANK_W_MAX-1:0] best_rank;
        logic [IDX_W_MAX-1:0]  best_idx;
        logic [PAGE_W_MAX-1:0] best_page;
    } scan_t;

    // update decision broadcast to every cell
    typedef struct packed {
        logic                  en;
        logic [IDX_W_MAX-1:0]  slot;
        logic                  write_page;
        logic                  age_all;
        logic [RANK_W_MAX-1:0] old_rank;
    } upd_t;

    localparam scan_t SCAN_IDLE = '0;

endpackage
`default_nettype wire

@@ design/lru_page_replacement.sv @@
// top level of the fully associative lru page replacement block
//
// Usage: raise start with page_number for one cycle while busy is low; the
// reference is taken at that clock edge and busy goes high. A search word
// walks the row of frame cells, one cell per cycle, collecting the first
// matching frame, the first empty frame and the oldest frame. In the cycle the
// word sits in the last cell the decision is applied to all cells at once and
// the result word (hit, frame_slot, evicted_valid, evicted_page, hit_total,
// fault_total) is registered from it and shown with done high for exactly one
// cycle. busy drops at the edge that raises done, so a new reference is taken
// only after the previous one is finished; the interval between references is
// set by the length of the cell row. The receiver cannot stall: each result is
// shown once and must be taken in that cycle.
// Configuration: cfg_write with cfg_data sets frames_in_use; write only while
// idle. A value of 0 acts as 1 and values above FRAMES act as FRAMES.
// Reset clears all valid marks, ranks, counters and sets frames_in_use to 8.
// hit_total and fault_total stay on the ports between results.
`default_nettype none
module lru_page_replacement #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lrupr_pkg::PAGE_IN_W-1:0] page_number,
    output logic                            done,
    output logic                            hit,
    output logic [lrupr_pkg::SLOT_W-1:0]    frame_slot,
    output logic                            evicted_valid,
    output logic [lrupr_pkg::PAGE_IN_W-1:0] evicted_page,
    output logic [lrupr_pkg::CNT_W-1:0]     hit_total,
    output logic [lrupr_pkg::CNT_W-1:0]     fault_total,
    input  logic                            cfg_write,
    input  logic [lrupr_pkg::CFG_W-1:0]     cfg_data
);
    import lrupr_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [CFG_W-1:0]      fiu_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [PAGE_W_MAX-1:0] page_wide;
    scan_t                 seed_reg;
    scan_t                 seed_next;
    scan_t                 cell_in [FRAMES];
    scan_t                 cell_out [FRAMES];
    logic [FRAMES-1:0]     active;
    scan_t                 last;
    logic                  start_acc;
    logic                  scan_end;
    logic                  dec_hit;
    logic                  dec_evict;
    logic [IDX_W_MAX-1:0]  dec_slot;
    upd_t                  upd;
    logic                  done_reg;
    logic                  hit_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  ev_valid_reg;
    logic [PAGE_IN_W-1:0]  ev_page_reg;
    logic [CNT_W-1:0]      hit_cnt_reg;
    logic [CNT_W-1:0]      hit_cnt_next;
    logic [CNT_W-1:0]      fault_cnt_reg;
    logic [CNT_W-1:0]      fault_cnt_next;

    assign start_acc = start && !busy_reg;
    assign page_wide = PAGE_W_MAX'(page_number);

    // row of frame cells
    genvar g;
    generate
        for (g = 0; g < FRAMES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign cell_in[g] = seed_reg;
                assign active[g]  = 1'b1;
            end
            else
            begin : g_body
                assign cell_in[g] = cell_out[g-1];
                assign active[g]  = (g < int'(fiu_reg));
            end
            lrupr_cell #(
                .FRAMES    (FRAMES),
                .PAGE_BITS (PAGE_BITS),
                .IDX       (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .active   (active[g]),
                .ref_page (page_reg),
                .scan_in  (cell_in[g]),
                .scan_out (cell_out[g]),
                .upd      (upd)
            );
        end
    endgenerate

    // decision from the finished search word
    assign last     = cell_out[FRAMES-1];
    assign scan_end = last.vld;

    always_comb
    begin
        dec_hit   = last.match_found;
        dec_evict = !last.match_found && !last.empty_found;
        if (last.match_found)
        begin
            dec_slot = last.match_idx;
        end
        else if (last.empty_found)
        begin
            dec_slot = last.empty_idx;
        end
        else
        begin
            dec_slot = last.best_idx;
        end
        upd.en         = scan_end;
        upd.slot       = dec_slot;
        upd.write_page = !dec_hit;
        upd.age_all    = !dec_hit;
        upd.old_rank   = last.match_rank;
    end

    // seed word, busy flag and saturating counters
    always_comb
    begin
        seed_next     = SCAN_IDLE;
        seed_next.vld = start_acc;

        busy_next = busy_reg;
        if (start_acc)
        begin
            busy_next = 1'b1;
        end
        else if (scan_end)
        begin
            busy_next = 1'b0;
        end

        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        if (scan_end && dec_hit && (hit_cnt_reg != '1))
        begin
            hit_cnt_next = hit_cnt_reg + CNT_W'(1);
        end
        if (scan_end && !dec_hit && (fault_cnt_reg != '1))
        begin
            fault_cnt_next = fault_cnt_reg + CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seed_reg      <= SCAN_IDLE;
            done_reg      <= 1'b0;
            fiu_reg       <= FRAMES_IN_USE_RST;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            seed_reg      <= seed_next;
            done_reg      <= scan_end;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            if (cfg_write)
            begin
                fiu_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start_acc)
        begin
            page_reg <= page_wide[PAGE_BITS-1:0];
        end
        if (scan_end)
        begin
            hit_reg      <= dec_hit;
            slot_reg     <= dec_slot[SLOT_W-1:0];
            ev_valid_reg <= dec_evict;
            ev_page_reg  <= dec_evict ? last.best_page[PAGE_IN_W-1:0] : '0;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign hit_total     = hit_cnt_reg;
    assign fault_total   = fault_cnt_reg;

endmodule
`default_nettype wire

@@ design/lrupr_cell.sv @@
// one frame cell: holds page, valid mark and recency rank, and merges the search word
`default_nettype none
module lrupr_cell #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 active,
    input  logic [PAGE_BITS-1:0] ref_page,
    input  lrupr_pkg::scan_t     scan_in,
    output lrupr_pkg::scan_t     scan_out,
    input  lrupr_pkg::upd_t      upd
);
    import lrupr_pkg::*;

    localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [RANK_W-1:0]    RANK_MAX = RANK_W'(FRAMES - 1);
    localparam logic [IDX_W_MAX-1:0] MY_IDX   = IDX_W_MAX'(IDX);

    logic [PAGE_BITS-1:0]  page_reg;
    logic                  valid_reg;
    logic                  valid_next;
    logic [RANK_W-1:0]     rank_reg;
    logic [RANK_W-1:0]     rank_next;
    scan_t                 scan_reg;
    scan_t                 scan_next;
    logic [RANK_W_MAX-1:0] rank_ext;
    logic                  is_slot;
    logic                  ages;

    assign rank_ext = RANK_W_MAX'(rank_reg);
    assign scan_out = scan_reg;

    // merge this frame into the passing search word
    always_comb
    begin
        scan_next = scan_in;
        if (active && valid_reg && !scan_in.match_found && (page_reg == ref_page))
        begin
            scan_next.match_found = 1'b1;
            scan_next.match_idx   = MY_IDX;
            scan_next.match_rank  = rank_ext;
        end
        if (active && !valid_reg && !scan_in.empty_found)
        begin
            scan_next.empty_found = 1'b1;
            scan_next.empty_idx   = MY_IDX;
        end
        if (active && (!scan_in.best_found || (rank_ext > scan_in.best_rank)))
        begin
            scan_next.best_found = 1'b1;
            scan_next.best_rank  = rank_ext;
            scan_next.best_idx   = MY_IDX;
            scan_next.best_page  = PAGE_W_MAX'(page_reg);
        end
    end

    // apply the broadcast decision: refresh the chosen frame, age younger ones on a hit and all others on a miss
    assign is_slot = (upd.slot == MY_IDX);
    assign ages    = active && valid_reg && !is_slot
                     && (upd.age_all || (rank_ext < upd.old_rank))
                     && (rank_reg < RANK_MAX);

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.en)
        begin
            if (is_slot)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
            end
            else if (ages)
            begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    // page store, undefined until first written
    always_ff @(posedge clk)
    begin
        if (upd.en && is_slot && upd.write_page)
        begin
            page_reg <= ref_page;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            scan_reg  <= SCAN_IDLE;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            scan_reg  <= scan_next;
        end
    end

endmodule
`default_nettype wire

@@ design/lrupr_checker.sv @@
// port-level checks for the lru page replacement block, bound to the top level
`default_nettype none
module lrupr_checker (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire                            busy,
    input  wire [lrupr_pkg::PAGE_IN_W-1:0] page_number,
    input  wire                            done,
    input  wire                            hit,
    input  wire [lrupr_pkg::SLOT_W-1:0]    frame_slot,
    input  wire                            evicted_valid,
    input  wire [lrupr_pkg::PAGE_IN_W-1:0] evicted_page,
    input  wire [lrupr_pkg::CNT_W-1:0]     hit_total,
    input  wire [lrupr_pkg::CNT_W-1:0]     fault_total,
    input  wire                            cfg_write,
    input  wire [lrupr_pkg::CFG_W-1:0]     cfg_data
);

    // an accepted reference makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // a result ends a busy period
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result word without a preceding busy period");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!evicted_valid && (evicted_page == '0)))
        else $error("hit word reports an eviction");

    // totals move only with a result word
    a_totals_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ($stable(hit_total) && $stable(fault_total)))
        else $error("totals changed without a result word");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the lru page replacement block
module testbench;
    import lrupr_pkg::*;

    localparam int NFRAMES     = FRAMES_DEF;
    localparam int LATENCY     = NFRAMES + 2;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 80;
    localparam int DIR_ROWS    = 27;

    // one result word as the block presents it
    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 ev_valid;
        logic [PAGE_IN_W-1:0] ev_page;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     fault_total;
    } ref_result_t;

    typedef enum logic {ROW_REF, ROW_CFG} row_kind_e;

    // directed row: a page reference or a frame count write
    typedef struct packed {
        row_kind_e            kind;
        logic [PAGE_IN_W-1:0] value;
        logic                 typed;
        ref_result_t          want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [PAGE_IN_W-1:0] page_number;
    logic                 done;
    logic                 hit;
    logic [SLOT_W-1:0]    frame_slot;
    logic                 evicted_valid;
    logic [PAGE_IN_W-1:0] evicted_page;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     fault_total;
    logic                 cfg_write;
    logic [CFG_W-1:0]     cfg_data;

    // lru predictor state
    logic [PAGE_IN_W-1:0] lru_page [NFRAMES];
    logic                 lru_valid [NFRAMES];
    int unsigned          lru_rank [NFRAMES];
    logic [CNT_W-1:0]     lru_hits;
    logic [CNT_W-1:0]     lru_faults;
    logic [CFG_W-1:0]     lru_frames;

    ref_result_t pending_results[$];
    int          err_count;
    int          stall_cycles;

    // directed table: after reset, extremes, shrunk and oversized frame counts
    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_REF, 16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd1}},
        '{ROW_REF, 16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd0, 32'd2}},
        '{ROW_REF, 16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd1, 32'd2}},
        '{ROW_REF, 16'hFFFF, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 32'd2, 32'd2}},
        '{ROW_CFG, 16'd1,    1'b0, '0},
        '{ROW_REF, 16'hFFFF, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 32'd2, 32'd3}},
        '{ROW_CFG, 16'd8,    1'b0, '0},
        // page now held twice, lowest frame wins
        '{ROW_REF, 16'hFFFF, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd3, 32'd3}},
        '{ROW_CFG, 16'd0,    1'b0, '0},
        '{ROW_REF, 16'hAAAA, 1'b1, '{1'b0, 3'd0, 1'b1, 16'hFFFF, 32'd3, 32'd4}},
        '{ROW_REF, 16'h5555, 1'b1, '{1'b0, 3'd0, 1'b1, 16'hAAAA, 32'd3, 32'd5}},
        '{ROW_CFG, 16'd15,   1'b0, '0},
        '{ROW_REF, 16'h0001, 1'b0, '0},
        '{ROW_REF, 16'h0002, 1'b0, '0},
        '{ROW_REF, 16'h0004, 1'b0, '0},
        '{ROW_REF, 16'h0008, 1'b0, '0},
        '{ROW_REF, 16'h0010, 1'b0, '0},
        '{ROW_REF, 16'h0020, 1'b0, '0},
        // full set with tied ranks
        '{ROW_REF, 16'h0040, 1'b0, '0},
        '{ROW_REF, 16'h8000, 1'b0, '0},
        '{ROW_REF, 16'h7FFF, 1'b0, '0},
        '{ROW_REF, 16'h5555, 1'b0, '0},
        '{ROW_CFG, 16'd3,    1'b0, '0},
        '{ROW_REF, 16'h00FF, 1'b0, '0},
        '{ROW_REF, 16'hFF00, 1'b0, '0},
        '{ROW_REF, 16'h0F0F, 1'b0, '0},
        '{ROW_CFG, 16'd8,    1'b0, '0}
    };

    lru_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page_number   (page_number),
        .done          (done),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .hit_total     (hit_total),
        .fault_total   (fault_total),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // effective frame count after clamping
    function automatic int active_frames(input logic [CFG_W-1:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > NFRAMES)
            return NFRAMES;
        return int'(cfg);
    endfunction

    task automatic lru_clear();
        for (int i = 0; i < NFRAMES; i++)
        begin
            lru_page[i]  = '0;
            lru_valid[i] = 1'b0;
            lru_rank[i]  = 0;
        end
        lru_hits   = '0;
        lru_faults = '0;
        lru_frames = FRAMES_IN_USE_RST;
    endtask

    // frame t becomes most recent, younger valid frames age by one
    task automatic make_recent(input int t, input int unsigned old_rank, input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i != t && lru_valid[i] && lru_rank[i] < old_rank && lru_rank[i] < NFRAMES - 1)
                lru_rank[i]++;
        end
        lru_rank[t] = 0;
    endtask

    // predict the result word of one page reference and update the frame set
    task automatic lru_predict(input logic [PAGE_IN_W-1:0] pg, output ref_result_t res);
        int          n;
        int          slot;
        bit          found;
        bit          empty;
        int unsigned best;
        n     = active_frames(lru_frames);
        slot  = 0;
        found = 1'b0;
        empty = 1'b0;
        res   = '0;
        for (int i = 0; i < n; i++)
        begin
            if (!found && lru_valid[i] && lru_page[i] == pg)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            if (lru_hits != '1)
                lru_hits++;
            make_recent(slot, lru_rank[slot], n);
        end
        else
        begin
            if (lru_faults != '1)
                lru_faults++;
            for (int i = 0; i < n; i++)
            begin
                if (!empty && !lru_valid[i])
                begin
                    empty = 1'b1;
                    slot  = i;
                end
            end
            if (!empty)
            begin
                // oldest frame, lowest index on ties
                best = lru_rank[0];
                slot = 0;
                for (int i = 1; i < n; i++)
                begin
                    if (lru_rank[i] > best)
                    begin
                        best = lru_rank[i];
                        slot = i;
                    end
                end
                res.ev_valid = 1'b1;
                res.ev_page  = lru_page[slot];
            end
            lru_valid[slot] = 1'b1;
            lru_page[slot]  = pg;
            make_recent(slot, 32'hFFFF_FFFF, n);
        end
        res.hit         = found;
        res.slot        = slot[SLOT_W-1:0];
        res.hit_total   = lru_hits;
        res.fault_total = lru_faults;
    endtask

    // drive one word after an idle gap, keep start high when there is no gap
    task automatic send_ref(input logic [PAGE_IN_W-1:0] pg, input int gap, input bit typed,
                            input ref_result_t want);
        ref_result_t predicted;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start       <= 1'b1;
        page_number <= pg;
        do
            @(posedge clk);
        while (busy);
        lru_predict(pg, predicted);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write  <= 1'b0;
        lru_frames = value;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin : result_check
        ref_result_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
            else if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, expected none, actual %0h",
                             $time, {hit, frame_slot, evicted_valid, evicted_page});
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("hit", CNT_W'(want.hit), CNT_W'(hit));
                    check_field("frame_slot", CNT_W'(want.slot), CNT_W'(frame_slot));
                    check_field("evicted_valid", CNT_W'(want.ev_valid),
                                CNT_W'(evicted_valid));
                    check_field("evicted_page", CNT_W'(want.ev_page), CNT_W'(evicted_page));
                    check_field("hit_total", want.hit_total, hit_total);
                    check_field("fault_total", want.fault_total, fault_total);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [PAGE_IN_W-1:0] pool [16];
        logic [PAGE_IN_W-1:0] pg;
        logic [CFG_W-1:0]     cfg;
        int                   pool_n;
        int                   gap_max;
        int                   pick;
        rst_n        = 1'b0;
        start        = 1'b0;
        page_number  = '0;
        cfg_write    = 1'b0;
        cfg_data     = '0;
        err_count    = 0;
        stall_cycles = 0;
        lru_clear();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (dir_table[idx])
        begin
            if (dir_table[idx].kind == ROW_CFG)
                write_frames(dir_table[idx].value[CFG_W-1:0]);
            else
                send_ref(dir_table[idx].value, $urandom_range(0, 3), dir_table[idx].typed,
                         dir_table[idx].want);
        end

        // random phases, each with its own frame count and working set
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: cfg = 4'd8;
                1: cfg = 4'd1;
                2: cfg = 4'd0;
                3: cfg = 4'd15;
                default: cfg = CFG_W'($urandom_range(0, 15));
            endcase
            write_frames(cfg);
            gap_max = (ph % 3 == 1) ? 0 : 10;
            pool_n  = active_frames(cfg) + $urandom_range(0, 3);
            for (int i = 0; i < pool_n; i++)
                pool[i] = PAGE_IN_W'($urandom_range(0, 16'hFFFF));
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    pg = pool[$urandom_range(0, pool_n - 1)];
                else if (pick < 95)
                    pg = PAGE_IN_W'($urandom_range(0, 16'hFFFF));
                else
                    pg = pick[0] ? 16'hFFFF : 16'h0000;
                // occasional full drain before the next word
                if ($urandom_range(0, 49) == 0)
                    drain();
                send_ref(pg, $urandom_range(0, gap_max), 1'b0, '0);
            end
        end

        drain();
        repeat (LATENCY + 4) @(negedge clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
design/lrupr_pkg.sv
design/lrupr_cell.sv
design/lru_page_replacement.sv
design/lrupr_checker.sv
sim/testbench.sv
